[rtl/poll_responder_packet_framer_unit_assert.svh]
// Assertion macros for the checker file of the poll responder framer.
`ifndef POLL_RESPONDER_PACKET_FRAMER_UNIT_ASSERT_SVH
`define POLL_RESPONDER_PACKET_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PRPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prpf: same-cycle property failed");

// Next-cycle implication, clocked on clk, off during reset.
`define PRPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prpf: next-cycle property failed");

`endif

[rtl/prpf_pkg.sv]
// Package: types, codes and frame helpers for the poll responder framer.
package prpf_pkg;

    localparam int PRPF_QUEUE_DEPTH = 8;

    localparam int FRAME_LEN   = 8;
    localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
    localparam logic [FRAME_IDX_W-1:0] FRAME_LAST_IDX = FRAME_IDX_W'(FRAME_LEN - 1);

    typedef enum logic [1:0] {
        ACT_RX     = 2'd0,
        ACT_SWITCH = 2'd1,
        ACT_PTZ    = 2'd2
    } action_t;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    localparam logic [7:0] POLL_BYTE     = 8'h50;
    localparam logic [7:0] SYNC_BYTE     = 8'hff;
    localparam logic [7:0] HDR_SWITCH    = 8'h11;
    localparam logic [7:0] HDR_PTZ       = 8'h21;
    localparam logic [7:0] SWITCH_TAIL   = 8'h55;
    localparam logic [7:0] ZOOM_IN_CODE  = 8'h40;
    localparam logic [7:0] ZOOM_OUT_CODE = 8'h80;
    localparam logic [7:0] SPEED_SIGN    = 8'h80;
    localparam logic [7:0] SPEED_NEG_MAX = 8'hff;
    localparam logic [7:0] INIT_SUM      = 8'h68;

    localparam logic [7:0] REG_FRAME [FRAME_LEN] =
        '{8'hff, 8'h00, 8'h41, 8'h11, 8'h55, 8'h00, 8'h00, 8'ha7};

    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        rx_byte;
        logic [7:0]        camera;
        logic [7:0]        monitor;
        logic              zoom_in;
        logic              zoom_out;
        logic signed [7:0] pan_speed;
        logic signed [7:0] tilt_speed;
    } prpf_req_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
    } prpf_rsp_t;

    // One queued command: switch keeps the monitor in p0; PTZ keeps zoom, pan, tilt
    typedef struct packed {
        logic       is_ptz;
        logic [7:0] camera;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] p2;
    } entry_t;

    // Power-up frame is a switch frame for camera 1, monitor 1
    localparam entry_t INIT_ENTRY = '{is_ptz: 1'b0, camera: 8'h01, p0: 8'h01,
                                      p1: 8'h00, p2: 8'h00};

    typedef enum logic [1:0] {
        JOB_REG,
        JOB_LAST,
        JOB_LOAD,
        JOB_DROP
    } job_kind_t;

    typedef struct packed {
        logic      valid;
        job_kind_t kind;
    } job_t;

    typedef enum logic {
        TX_IDLE,
        TX_SEND
    } tx_state_t;

    function automatic logic [7:0] encode_speed(input logic signed [7:0] v);
        logic [7:0] mag;
        logic [7:0] code;
        mag = 8'(-v);
        if (v == 8'sd0)
            code = 8'h00;
        else if (!v[7])
            code = v;
        else if (mag[7])
            code = SPEED_NEG_MAX;
        else
            code = SPEED_SIGN | mag;
        return code;
    endfunction

    function automatic entry_t build_entry(input prpf_req_t r);
        entry_t e;
        e.is_ptz = (r.action == ACT_PTZ);
        e.camera = r.camera;
        e.p0     = r.monitor;
        e.p1     = 8'h00;
        e.p2     = 8'h00;
        if (e.is_ptz)
        begin
            if (r.zoom_in)
                e.p0 = ZOOM_IN_CODE;
            else if (r.zoom_out)
                e.p0 = ZOOM_OUT_CODE;
            else
                e.p0 = 8'h00;
            e.p1 = encode_speed(r.pan_speed);
            e.p2 = encode_speed(r.tilt_speed);
        end
        return e;
    endfunction

    function automatic logic [7:0] entry_byte(input entry_t e,
                                              input logic [FRAME_IDX_W-1:0] idx,
                                              input logic [7:0] sum);
        logic [7:0] b;
        case (idx)
            FRAME_IDX_W'(0): b = SYNC_BYTE;
            FRAME_IDX_W'(1): b = 8'h00;
            FRAME_IDX_W'(2): b = e.is_ptz ? HDR_PTZ : HDR_SWITCH;
            FRAME_IDX_W'(3): b = e.is_ptz ? e.p0 : 8'h00;
            FRAME_IDX_W'(4): b = e.camera;
            FRAME_IDX_W'(5): b = e.is_ptz ? e.p1 : e.p0;
            FRAME_IDX_W'(6): b = e.is_ptz ? e.p2 : SWITCH_TAIL;
            default:         b = sum;
        endcase
        return b;
    endfunction

    // 8-bit sum over bytes 1..6 of the frame
    function automatic logic [7:0] entry_sum(input entry_t e);
        logic [7:0] s;
        s = 8'h00;
        for (int i = 1; i < FRAME_LEN - 1; i++)
            s = s + entry_byte(e, FRAME_IDX_W'(i), 8'h00);
        return s;
    endfunction

endpackage

[rtl/prpf_stream_if.sv]
// Valid/ready stream interface carrying one payload word per handshake.
interface prpf_stream_if #(
    parameter type data_t = logic
) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/prpf_cmd_queue.sv]
// Command FIFO: synchronous entry memory with head, tail and fill count.
module prpf_cmd_queue
    import prpf_pkg::*;
#(
    parameter int DEPTH = PRPF_QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   full,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign pop_entry = rd_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        if (push)
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[tail_reg] <= push_entry;
    end

    // Read data holds until the next pop
    always_ff @(posedge clk)
    begin
        if (pop)
            rd_data_reg <= mem[head_reg];
    end

endmodule

[rtl/prpf_frame_tx.sv]
// Frame sender: job slot, last-frame store and output word register.
module prpf_frame_tx
    import prpf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  job_t           job,
    input  entry_t         pop_entry,
    output logic           job_busy,
    prpf_stream_if.source  rsp
);

    tx_state_t state_reg, state_next;

    logic                   job_valid_reg;
    job_kind_t              job_kind_reg;
    logic [FRAME_IDX_W-1:0] idx_reg;
    logic                   reg_frame_reg;
    entry_t                 entry_reg;
    logic [7:0]             sum_reg;
    logic                   out_valid_reg;
    prpf_rsp_t              out_word_reg;

    logic       out_free;
    logic       frame_end;
    logic       job_is_frame;
    logic       job_take;
    logic       send_word;
    logic       drop_word;
    logic [7:0] cur_byte;

    assign out_free     = !out_valid_reg || rsp.ready;
    assign frame_end    = (state_reg == TX_SEND) && out_free && (idx_reg == FRAME_LAST_IDX);
    assign job_is_frame = (job_kind_reg != JOB_DROP);
    // A frame job may start on the cycle the previous frame sends its last word
    assign job_take     = job_valid_reg &&
                          (job_is_frame ? ((state_reg == TX_IDLE) || frame_end)
                                        : ((state_reg == TX_IDLE) && out_free));
    assign cur_byte     = reg_frame_reg ? REG_FRAME[idx_reg]
                                        : entry_byte(entry_reg, idx_reg, sum_reg);

    assign job_busy  = job_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_word_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TX_IDLE:
            begin
                if (job_take && job_is_frame)
                    state_next = TX_SEND;
            end
            TX_SEND:
            begin
                if (frame_end && !job_take)
                    state_next = TX_IDLE;
            end
            default: state_next = TX_IDLE;
        endcase
    end

    always_comb
    begin
        send_word = 1'b0;
        drop_word = 1'b0;
        case (state_reg)
            TX_IDLE: drop_word = job_take && !job_is_frame;
            TX_SEND: send_word = out_free;
            default:
            begin
                send_word = 1'b0;
                drop_word = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TX_IDLE;
            job_valid_reg <= 1'b0;
            job_kind_reg  <= JOB_LAST;
            idx_reg       <= '0;
            reg_frame_reg <= 1'b0;
            entry_reg     <= INIT_ENTRY;
            sum_reg       <= INIT_SUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (job.valid)
            begin
                job_valid_reg <= 1'b1;
                job_kind_reg  <= job.kind;
            end
            else if (job_take)
                job_valid_reg <= 1'b0;

            if (job_take && job_is_frame)
            begin
                idx_reg       <= '0;
                reg_frame_reg <= (job_kind_reg == JOB_REG);
            end
            else if (send_word)
                idx_reg <= idx_reg + 1'b1;

            // Replace the stored frame only when a queued command is popped
            if (job_take && (job_kind_reg == JOB_LOAD))
            begin
                entry_reg <= pop_entry;
                sum_reg   <= entry_sum(pop_entry);
            end

            if (send_word || drop_word)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (send_word)
        begin
            out_word_reg.kind    <= KIND_TX;
            out_word_reg.tx_byte <= cur_byte;
            out_word_reg.last    <= (idx_reg == FRAME_LAST_IDX);
        end
        else if (drop_word)
        begin
            out_word_reg.kind    <= KIND_DROP;
            out_word_reg.tx_byte <= 8'h00;
            out_word_reg.last    <= 1'b1;
        end
    end

endmodule

[rtl/poll_responder_packet_framer_unit.sv]
// Top level of the polled responder: decode, command queue and frame sender.
//
//  channel | dir | payload     | words per item
//  --------+-----+-------------+--------------------------------------
//  req     | in  | prpf_req_t  | one
//  rsp     | out | prpf_rsp_t  | 8 per poll answer, 1 per drop, else 0
//
// Commands may arrive every cycle while req.ready is high. A poll sends 8 words,
// one per cycle from the output register while rsp.ready is high; a poll behind
// a frame in flight waits in a one-entry job slot, which lowers req.ready while
// it is full. A popped entry is read from the queue memory in the cycle after
// the poll is taken. Reset is immediate: no clearing pass, since the queue
// memory is only read at entries already written.
module poll_responder_packet_framer_unit
    import prpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = PRPF_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    prpf_stream_if.sink   req,
    prpf_stream_if.source rsp
);

    logic   registered_reg;
    logic   accept;
    logic   is_poll;
    logic   is_cmd;
    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    logic   job_busy;
    job_t   job;
    entry_t push_entry;
    entry_t pop_entry;

    assign req.ready = !job_busy;
    assign accept    = req.valid && req.ready;
    assign is_poll   = (req.data.action == ACT_RX) && (req.data.rx_byte == POLL_BYTE);
    assign is_cmd    = req.data.action inside {ACT_SWITCH, ACT_PTZ};

    assign push       = accept && is_cmd && !q_full;
    assign pop        = accept && is_poll && registered_reg && !q_empty;
    assign push_entry = build_entry(req.data);

    always_comb
    begin
        job.valid = accept && (is_poll || (is_cmd && q_full));
        if (!is_poll)
            job.kind = JOB_DROP;
        else if (!registered_reg)
            job.kind = JOB_REG;
        else if (q_empty)
            job.kind = JOB_LAST;
        else
            job.kind = JOB_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            registered_reg <= 1'b0;
        else if (accept && is_poll)
            registered_reg <= 1'b1;
    end

    prpf_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    prpf_frame_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .pop_entry (pop_entry),
        .job_busy  (job_busy),
        .rsp       (rsp)
    );

endmodule

[rtl/prpf_checker.sv]
// Port-level checker for the poll responder framer, bound to the top level.
`include "poll_responder_packet_framer_unit_assert.svh"

module prpf_checker
    import prpf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input prpf_rsp_t rsp_data
);

    logic [FRAME_IDX_W-1:0] pos_reg;
    logic                   seen_req_reg;
    logic                   rsp_fire;

    assign rsp_fire = rsp_valid && rsp_ready;

    // Track the byte position within the frame on the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            seen_req_reg <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
                seen_req_reg <= 1'b1;
            if (rsp_fire && (rsp_data.kind == KIND_TX))
                pos_reg <= rsp_data.last ? '0 : pos_reg + 1'b1;
        end
    end

    `PRPF_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
    `PRPF_ASSERT_IMP(a_last_pos, rsp_fire && (rsp_data.kind == KIND_TX), rsp_data.last == (pos_reg == FRAME_LAST_IDX))
    `PRPF_ASSERT_IMP(a_sync_first, rsp_fire && (rsp_data.kind == KIND_TX) && (pos_reg == '0), rsp_data.tx_byte == SYNC_BYTE)
    `PRPF_ASSERT_IMP(a_drop_between, rsp_valid && (rsp_data.kind == KIND_DROP), rsp_data.last && (pos_reg == '0))
    `PRPF_ASSERT_IMP(a_no_word_early, !seen_req_reg, !rsp_valid)

endmodule

bind poll_responder_packet_framer_unit prpf_checker u_prpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
